[rtl/core/sequential_list_engine_core_defines.svh]
// assertion macros for the list engine
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define SLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sle_pkg.sv]
package sle_pkg;

    localparam int SLE_CAPACITY = 64;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_ERASE      = 3'd5,
        CMD_FIND       = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [6:0]         position;
        logic signed [31:0] value;
    } sle_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] found_index;
        logic [6:0] count;
    } sle_out_t;

endpackage

[rtl/core/sequential_list_engine_core.sv]
// channel   dir   ports                     transfer carries
// s_        in    s_valid s_ready s_data    one command (sle_in_t)
// m_        out   m_valid m_ready m_data    one response (sle_out_t)
//
// flow: push back, pop back, clear and rejected commands go straight to the done
// state; push front / insert shift entries up, erase / pop front shift them down,
// each entry read then written; find reads and compares entries to the first hit
// reset: aresetn low clears the count, the sequencer and the output valid
// stalls: a waiting response sits in the output register while the next command
// is taken; the sequencer holds in its done state while that register is full
module sequential_list_engine_core
    import sle_pkg::*;
#(
    parameter int CAPACITY = SLE_CAPACITY
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sle_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sle_out_t m_data
);

`include "sequential_list_engine_core_defines.svh"

    // count holds 0..CAPACITY, memory index 0..CAPACITY-1
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
    localparam int IXO_W  = (IDX_W > 6) ? IDX_W : 6;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SHUP_RD = 8'b0000_0010,
        S_SHUP_WR = 8'b0000_0100,
        S_SHDN_RD = 8'b0000_1000,
        S_SHDN_WR = 8'b0001_0000,
        S_FIND_RD = 8'b0010_0000,
        S_FIND_CM = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    // entry memory, single port, registered read
    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd_data_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic signed [31:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    state_t             state_reg,   state_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic               m_valid_reg, m_valid_next;
    sle_out_t           m_data_reg,  m_data_next;
    logic [CNT_W-1:0]   k_reg,       k_next;      // walking index
    logic [CNT_W-1:0]   at_reg,      at_next;     // shift-up target position
    logic signed [31:0] val_reg,     val_next;
    status_t            status_reg,  status_next;
    logic [IDX_W-1:0]   idx_reg,     idx_next;

    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   count_ext;
    logic [CNT_W:0]     k_plus1;
    logic [IXO_W-1:0]   idx_ext;
    logic               in_find;
    logic               in_done;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign pos_ext   = CMP_W'(s_data.position);
    assign count_ext = CMP_W'(count_reg);
    assign k_plus1   = {1'b0, k_reg} + 1'b1;
    assign idx_ext   = IXO_W'(idx_reg);
    assign in_find   = (state_reg == S_FIND_RD) || (state_reg == S_FIND_CM);
    assign in_done   = (state_reg == S_DONE);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        k_next       = k_reg;
        at_next      = at_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        idx_next     = idx_reg;
        wr_en        = 1'b0;
        wr_addr      = k_reg[IDX_W-1:0];
        wr_data      = rd_data_reg;
        rd_en        = 1'b0;
        rd_addr      = k_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    val_next    = s_data.value;
                    status_next = ST_OK;
                    idx_next    = '0;
                    state_next  = S_DONE;
                    case (cmd_t'(s_data.cmd))
                        CMD_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = s_data.value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                at_next    = '0;
                                k_next     = count_reg;
                                state_next = S_SHUP_RD;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                k_next     = '0;
                                state_next = S_SHDN_RD;
                            end
                        end
                        CMD_INSERT: begin
                            if (pos_ext > count_ext) begin
                                status_next = ST_BADPOS;
                            end else if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                at_next    = CNT_W'(pos_ext);
                                k_next     = count_reg;
                                state_next = S_SHUP_RD;
                            end
                        end
                        CMD_ERASE: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else if (pos_ext >= count_ext) begin
                                status_next = ST_BADPOS;
                            end else begin
                                k_next     = CNT_W'(pos_ext);
                                state_next = S_SHDN_RD;
                            end
                        end
                        CMD_FIND: begin
                            status_next = ST_NOTFOUND;
                            k_next      = '0;
                            state_next  = S_FIND_RD;
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            // move entries up from the top down to the target, then drop the value in
            S_SHUP_RD: begin
                if (k_reg == at_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = at_reg[IDX_W-1:0];
                    wr_data    = val_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(k_reg - 1'b1);
                    state_next = S_SHUP_WR;
                end
            end
            S_SHUP_WR: begin
                wr_en      = 1'b1;
                wr_addr    = k_reg[IDX_W-1:0];
                wr_data    = rd_data_reg;
                k_next     = k_reg - 1'b1;
                state_next = S_SHUP_RD;
            end
            // move entries down onto the erased slot
            S_SHDN_RD: begin
                if (k_plus1 >= {1'b0, count_reg}) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = k_plus1[IDX_W-1:0];
                    state_next = S_SHDN_WR;
                end
            end
            S_SHDN_WR: begin
                wr_en      = 1'b1;
                wr_addr    = k_reg[IDX_W-1:0];
                wr_data    = rd_data_reg;
                k_next     = k_plus1[CNT_W-1:0];
                state_next = S_SHDN_RD;
            end
            // linear scan, lowest index wins
            S_FIND_RD: begin
                if (k_reg >= count_reg) begin
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = k_reg[IDX_W-1:0];
                    state_next = S_FIND_CM;
                end
            end
            S_FIND_CM: begin
                if (rd_data_reg == val_reg) begin
                    status_next = ST_OK;
                    idx_next    = k_reg[IDX_W-1:0];
                    state_next  = S_DONE;
                end else begin
                    k_next     = k_plus1[CNT_W-1:0];
                    state_next = S_FIND_RD;
                end
            end
            // hand the response to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = status_reg;
                    m_data_next.found_index = idx_ext[5:0];
                    m_data_next.count       = count_ext[6:0];
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        k_reg      <= k_next;
        at_reg     <= at_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // a command transfer always leaves the idle state
    `SLE_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, !s_ready, "ready after accept")
    // count stays within capacity
    `SLE_ASSERT_IMP(a_count_cap, aclk, aresetn, 1'b1, count_reg <= CAP_CNT, "count over capacity")
    // the scan never modifies the list
    `SLE_ASSERT_IMP(a_find_ro, aclk, aresetn, in_find, !wr_en, "write during find")
    // a new response only comes out of the done state
    `SLE_ASSERT_IMP(a_resp_src, aclk, aresetn, $rose(m_valid), $past(in_done), "stray response")

endmodule
